FILE: rtl/cbq_pkg.sv
// types, constants and pointer helpers for the circular buffer queue
package cbq_pkg;

    localparam int RING_SLOTS    = 128;
    localparam int ELEMENT_WIDTH = 32;
    localparam int PTR_W         = $clog2(RING_SLOTS);
    localparam int DATA_W        = 32;
    localparam int INDEX_W       = 7;
    localparam int LEN_W         = 7;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_STATUS = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_command           command;
        logic [DATA_W-1:0]  data_in;
        logic [INDEX_W-1:0] index;
    } t_cmd_beat;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
        logic              is_full;
    } t_result_beat;

    function automatic t_ptr ring_next(input t_ptr p);
        if (p == t_ptr'(RING_SLOTS - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    function automatic logic [PTR_W:0] ring_length(input t_ptr head, input t_ptr tail);
        if (tail >= head) begin
            return {1'b0, tail} - {1'b0, head};
        end
        return {1'b0, tail} + (PTR_W+1)'(RING_SLOTS) - {1'b0, head};
    endfunction

    function automatic t_ptr ring_offset(input t_ptr head, input logic [INDEX_W-1:0] idx);
        logic [PTR_W+INDEX_W:0] sum;
        sum = (PTR_W+INDEX_W+1)'(head) + (PTR_W+INDEX_W+1)'(idx);
        if (sum >= (PTR_W+INDEX_W+1)'(RING_SLOTS)) begin
            sum = sum - (PTR_W+INDEX_W+1)'(RING_SLOTS);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/cbq_ram.sv
// generic single-write, single-read ram with registered read data
module cbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/circular_buffer_queue.sv
// ring-buffer fifo top level: enqueue, dequeue, peek and status commands
// result: registered strobe, raised in the cycle after the command beat is taken
// throughput: one command per cycle, busy stays low; pointers update at accept
// and the slot ram is written on enqueue before any later read of that slot
// reset: synchronous, clears head and tail pointers and the result strobe
// slot contents are undefined until written; no clearing pass
module circular_buffer_queue
    import cbq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_beat    i_cmd,
    output logic         o_result_valid,
    output t_result_beat o_result
);

    t_ptr              r_head, r_tail;
    t_ptr              n_head, n_tail;
    logic              r_valid;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_length;
    logic              r_is_empty, r_is_full;
    logic              r_has_data, n_has_data;
    logic              accept;
    logic              full_now, empty_now;
    logic [PTR_W:0]    len_now, len_next;
    logic              wr_en;
    t_ptr              rd_addr;
    logic [ELEMENT_WIDTH-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full_now  = (ring_next(r_tail) == r_head);
    assign empty_now = (r_head == r_tail);
    assign len_now   = ring_length(r_head, r_tail);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_status   = ST_OK;
        n_has_data = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = r_head;
        unique case (i_cmd.command)
            CMD_ENQ: begin
                if (full_now) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en  = accept;
                    n_tail = ring_next(r_tail);
                end
            end
            CMD_DEQ: begin
                if (empty_now) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_has_data = 1'b1;
                    n_head     = ring_next(r_head);
                end
            end
            CMD_PEEK: begin
                rd_addr = ring_offset(r_head, i_cmd.index);
                if ((PTR_W+INDEX_W+1)'(i_cmd.index) >= (PTR_W+INDEX_W+1)'(len_now)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_has_data = 1'b1;
                end
            end
            CMD_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    assign len_next = ring_length(n_head, n_tail);

    cbq_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (RING_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.data_in[ELEMENT_WIDTH-1:0]),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
        end
        if (accept) begin
            r_status   <= n_status;
            r_has_data <= n_has_data;
            r_length   <= LEN_W'(len_next);
            r_is_empty <= (n_head == n_tail);
            r_is_full  <= (ring_next(n_tail) == n_head);
        end
    end

    assign o_result_valid    = r_valid;
    assign o_result.data_out = r_has_data ? DATA_W'(rd_data) : '0;
    assign o_result.status   = r_status;
    assign o_result.length   = r_length;
    assign o_result.is_empty = r_is_empty;
    assign o_result.is_full  = r_is_full;

endmodule
